/* rtl/core/qcr_pkg.sv */
// shared widths, register indexes and item types for the quadtree cell refine step
package qcr_pkg;

  localparam int CoordW      = 25;
  localparam int DepthW      = 4;
  localparam int CfgW        = 25;
  localparam int CfgIdxW     = 2;
  localparam int FracBitsDef = 24;
  localparam int QueueDepth  = 4;
  localparam int TdataW      = 80;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgMinSize  = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgSizeGain = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgMinDepth = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgMaxDepth = 2'd3;

  typedef struct packed {
    logic [CoordW-1:0] min_size;
    logic [CoordW-1:0] size_gain;
    logic [DepthW-1:0] min_depth;
    logic [DepthW-1:0] max_depth;
  } cfg_t;

  // classified cell, split is only meaningful after the front end
  typedef struct packed {
    logic [CoordW-1:0] x;
    logic [CoordW-1:0] y;
    logic [CoordW-1:0] size;
    logic [DepthW-1:0] depth;
    logic              split;
  } cell_t;

  typedef struct packed {
    logic [CoordW-1:0] x;
    logic [CoordW-1:0] y;
    logic [CoordW-1:0] size;
    logic [DepthW-1:0] depth;
    logic              leaf;
    logic              last;
  } res_t;

endpackage

/* rtl/core/qcr_front.sv */
// front end: pipelined exact size test that classifies each cell as split or leaf
module qcr_front import qcr_pkg::*; #(
  parameter int FRAC_BITS = FracBitsDef
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  cfg_t  cfg_i,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  input  cell_t in_cell_i,
  output logic  out_valid_o,
  input  logic  out_ready_i,
  output cell_t out_cell_o
);

  // doubled coordinates keep the half-size corner offsets exact
  localparam int AbsW   = CoordW + 2;
  localparam int SqW    = 2 * AbsW;
  localparam int PartW  = CoordW + AbsW;
  localparam int ProdW  = SqW + CoordW;
  localparam int RShift = 2 * FRAC_BITS + 2;
  localparam int RightW = CoordW + RShift;
  localparam int CmpW   = (ProdW > RightW) ? ProdW : RightW;

  typedef struct packed {
    cell_t             item;
    logic              force_split;
    logic              may_test;
    logic [CoordW-1:0] diff;
  } ctl_t;

  logic                en;
  logic                v1_q, v2_q, v3_q, v4_q, v5_q;
  ctl_t                c1_d, c1_q, c2_q, c3_q, c4_q;
  cell_t               c5_d, c5_q;
  logic [AbsW-1:0]     base_c, adiff_c;
  logic [AbsW:0]       sdiff_c, sneg_c;
  logic [AbsW-1:0]     base_q, adiff_q, amin_q;
  logic [SqW-1:0]      sq_q;
  logic [PartW-1:0]    plo_q, phi_q;
  logic [CmpW-1:0]     left_c, right_c;

  assign en         = !v5_q || out_ready_i;
  assign in_ready_o = en;

  // center sum, and center sum minus twice the size (the lower left corner
  // and the two mixed corners give only these and the upper corner sum)
  assign base_c  = {1'b0, in_cell_i.x, 1'b0} + {1'b0, in_cell_i.y, 1'b0};
  assign sdiff_c = {1'b0, base_c} - {2'b0, in_cell_i.size, 1'b0};
  assign sneg_c  = -sdiff_c;
  assign adiff_c = sdiff_c[AbsW] ? sneg_c[AbsW-1:0] : sdiff_c[AbsW-1:0];

  always_comb begin
    c1_d             = '0;
    c1_d.item        = in_cell_i;
    c1_d.item.split  = 1'b0;
    c1_d.force_split = in_cell_i.depth < cfg_i.min_depth;
    c1_d.may_test    = (in_cell_i.depth < cfg_i.max_depth) &&
                       (cfg_i.min_size < in_cell_i.size);
    c1_d.diff        = in_cell_i.size - cfg_i.min_size;
  end

  assign left_c  = CmpW'(plo_q) + (CmpW'(phi_q) << AbsW);
  assign right_c = CmpW'(c4_q.diff) << RShift;

  always_comb begin
    c5_d       = c4_q.item;
    c5_d.split = c4_q.force_split || (c4_q.may_test && (left_c < right_c));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else if (en) begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      c1_q    <= c1_d;
      base_q  <= base_c;
      adiff_q <= adiff_c;
      c2_q    <= c1_q;
      amin_q  <= (adiff_q < base_q) ? adiff_q : base_q;
      c3_q    <= c2_q;
      sq_q    <= SqW'(amin_q) * SqW'(amin_q);
      c4_q    <= c3_q;
      plo_q   <= PartW'(cfg_i.size_gain) * PartW'(sq_q[AbsW-1:0]);
      phi_q   <= PartW'(cfg_i.size_gain) * PartW'(sq_q[SqW-1:AbsW]);
      c5_q    <= c5_d;
    end
  end

  assign out_valid_o = v5_q;
  assign out_cell_o  = c5_q;

endmodule

/* rtl/core/qcr_queue.sv */
// short queue of classified cells between front and back end
module qcr_queue import qcr_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_valid_i,
  output logic  push_ready_o,
  input  cell_t push_cell_i,
  output logic  pop_valid_o,
  input  logic  pop_i,
  output cell_t pop_cell_o
);

  localparam int PtrW = $clog2(QueueDepth);
  localparam int CntW = $clog2(QueueDepth + 1);

  cell_t             mem_q [QueueDepth];
  logic [PtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic              wr, rd;

  assign push_ready_o = cnt_q < CntW'(QueueDepth);
  assign pop_valid_o  = cnt_q != '0;
  assign pop_cell_o   = mem_q[rd_ptr_q];
  assign wr           = push_valid_i && push_ready_o;
  assign rd           = pop_i && pop_valid_o;

  always_comb begin
    cnt_d = cnt_q;
    if (wr && !rd) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (rd && !wr) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (wr) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (rd) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr) begin
      mem_q[wr_ptr_q] <= push_cell_i;
    end
  end

endmodule

/* rtl/core/qcr_back.sv */
// back end: expands a split cell into four children, or passes a leaf, into the output register
module qcr_back import qcr_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  head_valid_i,
  input  cell_t head_cell_i,
  output logic  pop_o,
  output logic  m_valid_o,
  input  logic  m_ready_i,
  output res_t  m_res_o
);

  logic [1:0]        k_q;
  logic              o_valid_q;
  res_t              o_res_q, res_c;
  logic              slot_free, take, last;
  logic [CoordW-3:0] quarter;
  logic [CoordW:0]   x_add, x_sub, y_add, y_sub;
  logic              x_plus, y_plus;

  assign slot_free = !o_valid_q || m_ready_i;
  assign take      = head_valid_i && slot_free;
  assign last      = !head_cell_i.split || (k_q == 2'd3);
  assign pop_o     = take && last;

  // child order: lower left, lower right, upper right, upper left
  assign x_plus  = (k_q == 2'd1) || (k_q == 2'd2);
  assign y_plus  = k_q[1];
  assign quarter = head_cell_i.size[CoordW-1:2];

  assign x_add = {1'b0, head_cell_i.x} + {3'b0, quarter};
  assign x_sub = {1'b0, head_cell_i.x} - {3'b0, quarter};
  assign y_add = {1'b0, head_cell_i.y} + {3'b0, quarter};
  assign y_sub = {1'b0, head_cell_i.y} - {3'b0, quarter};

  always_comb begin
    res_c = '0;
    if (!head_cell_i.split) begin
      res_c.x     = head_cell_i.x;
      res_c.y     = head_cell_i.y;
      res_c.size  = head_cell_i.size;
      res_c.depth = head_cell_i.depth;
      res_c.leaf  = 1'b1;
      res_c.last  = 1'b1;
    end else begin
      // saturate at the top of the range and at zero
      if (x_plus) begin
        res_c.x = x_add[CoordW] ? '1 : x_add[CoordW-1:0];
      end else begin
        res_c.x = x_sub[CoordW] ? '0 : x_sub[CoordW-1:0];
      end
      if (y_plus) begin
        res_c.y = y_add[CoordW] ? '1 : y_add[CoordW-1:0];
      end else begin
        res_c.y = y_sub[CoordW] ? '0 : y_sub[CoordW-1:0];
      end
      res_c.size  = {1'b0, head_cell_i.size[CoordW-1:1]};
      res_c.depth = head_cell_i.depth + DepthW'(1);
      res_c.leaf  = 1'b0;
      res_c.last  = k_q == 2'd3;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q       <= '0;
      o_valid_q <= 1'b0;
    end else begin
      if (take) begin
        o_valid_q <= 1'b1;
        k_q       <= last ? 2'd0 : k_q + 2'd1;
      end else if (m_ready_i) begin
        o_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      o_res_q <= res_c;
    end
  end

  assign m_valid_o = o_valid_q;
  assign m_res_o   = o_res_q;

endmodule

/* rtl/core/quadtree_cell_refine_step_top.sv */
// top level of the quadtree cell refine step: config registers, front end, queue, back end
//
// usage
// - input stream s_axis: one square cell per transfer (center, size, depth, fixed point
//   with FRAC_BITS fraction bits); output stream m_axis: one cell per transfer
// - a cell that refines gives four children in the order lower left, lower right,
//   upper right, upper left (tuser low, tlast on the fourth); a kept cell comes out
//   once with tuser and tlast high
// - path: the first result of a cell passes the five front stages, the queue and the
//   output register before m_axis_tvalid rises
// - throughput: the output register moves one result per cycle while m_axis_tready
//   is high, so a leaf cell gives one result and a splitting cell four on the output
//   port; the front end takes a cell every cycle while the four-entry queue has room
// - the front end stalls only when its last stage holds a cell and the queue is full
// - when the receiver holds tready low the output register keeps its result, the queue
//   fills, and then s_axis_tready drops; nothing is lost or repeated
// - reset clears all valid state and loads the register defaults: min_size 1/32,
//   size_gain 1/8, min_depth 2, max_depth 6
// - configuration writes (cfg_we_i) take effect at once; write only while the block is
//   empty
module quadtree_cell_refine_step_top import qcr_pkg::*; #(
  parameter int FRAC_BITS = FracBitsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // config write port
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgW-1:0]    cfg_wdata_i,
  // input stream
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [TdataW-1:0]  s_axis_tdata,   // center_x, center_y, cell_size, depth
  // output stream
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [TdataW-1:0]  m_axis_tdata,   // out_x, out_y, out_size, out_depth
  output logic               m_axis_tuser,   // is_leaf
  output logic               m_axis_tlast    // last_of_run
);

  // register defaults follow the fraction width, masked to the register width
  localparam logic [CfgW-1:0] MinSizeRst  = CfgW'(64'd1 << (FRAC_BITS - 5));
  localparam logic [CfgW-1:0] SizeGainRst = CfgW'(64'd1 << (FRAC_BITS - 3));
  localparam logic [DepthW-1:0] MinDepthRst = 4'd2;
  localparam logic [DepthW-1:0] MaxDepthRst = 4'd6;

  cfg_t  cfg_q;
  cell_t in_cell, fq_cell, head_cell;
  logic  fq_valid, fq_ready, head_valid, pop;
  res_t  res;

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.min_size  <= MinSizeRst;
      cfg_q.size_gain <= SizeGainRst;
      cfg_q.min_depth <= MinDepthRst;
      cfg_q.max_depth <= MaxDepthRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgMinSize:  cfg_q.min_size  <= cfg_wdata_i;
        CfgSizeGain: cfg_q.size_gain <= cfg_wdata_i;
        CfgMinDepth: cfg_q.min_depth <= cfg_wdata_i[DepthW-1:0];
        CfgMaxDepth: cfg_q.max_depth <= cfg_wdata_i[DepthW-1:0];
        default: begin
        end
      endcase
    end
  end

  // unpack the input transfer, lowest field first
  always_comb begin
    in_cell.x     = s_axis_tdata[CoordW-1:0];
    in_cell.y     = s_axis_tdata[2*CoordW-1:CoordW];
    in_cell.size  = s_axis_tdata[3*CoordW-1:2*CoordW];
    in_cell.depth = s_axis_tdata[3*CoordW+DepthW-1:3*CoordW];
    in_cell.split = 1'b0;
  end

  qcr_front #(
    .FRAC_BITS (FRAC_BITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_cell_i   (in_cell),
    .out_valid_o (fq_valid),
    .out_ready_i (fq_ready),
    .out_cell_o  (fq_cell)
  );

  qcr_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (fq_valid),
    .push_ready_o (fq_ready),
    .push_cell_i  (fq_cell),
    .pop_valid_o  (head_valid),
    .pop_i        (pop),
    .pop_cell_o   (head_cell)
  );

  qcr_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_cell_i  (head_cell),
    .pop_o        (pop),
    .m_valid_o    (m_axis_tvalid),
    .m_ready_i    (m_axis_tready),
    .m_res_o      (res)
  );

  // pack the output transfer, zero fill to whole bytes
  assign m_axis_tdata = {{(TdataW - 3*CoordW - DepthW){1'b0}},
                         res.depth, res.size, res.y, res.x};
  assign m_axis_tuser = res.leaf;
  assign m_axis_tlast = res.last;

  // a kept cell is always the whole run
  a_leaf_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser) |-> m_axis_tlast)
    else $error("leaf result without tlast");

  // a child is one level below its parent, so its depth is never zero
  a_child_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tuser) |->
      (m_axis_tdata[3*CoordW+DepthW-1:3*CoordW] != '0))
    else $error("child result with depth zero");

  // the input side only stalls behind a full queue, which means a result is waiting
  a_stall_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid)
    else $error("input stalled with no result pending");

endmodule

/* tb/quadtree_cell_refine_step_top_test.sv */
// self-checking testbench for the quadtree cell refine step top level
module quadtree_cell_refine_step_top_test;
  import qcr_pkg::*;

  localparam int FracBits = FracBitsDef;
  localparam int Unit = 1 << FracBits;                  // fixed point 1.0
  localparam logic [CoordW-1:0] TopCoord = '1;          // largest coordinate code
  localparam int RunLimit = 200000;                     // watchdog, in clock cycles
  localparam int DrainCycles = 20;                      // settle time at the end of a drain
  localparam int HoldAt = 80;                           // input count that starts the hold-off
  localparam int HoldCycles = 300;                      // receiver hold-off length

  // one input cell as the testbench sees it
  typedef struct packed {
    logic [CoordW-1:0] x;
    logic [CoordW-1:0] y;
    logic [CoordW-1:0] size;
    logic [DepthW-1:0] depth;
  } cell_s;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i = '0;
  logic [CfgW-1:0]    cfg_wdata_i = '0;
  logic               s_axis_tvalid = 1'b0;
  logic               s_axis_tready;
  logic [TdataW-1:0]  s_axis_tdata = '0;  // center_x, center_y, cell_size, depth
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b0;
  logic [TdataW-1:0]  m_axis_tdata;       // out_x, out_y, out_size, out_depth
  logic               m_axis_tuser;       // is_leaf
  logic               m_axis_tlast;       // last_of_run

  // testbench copy of the configuration registers
  logic [CoordW-1:0] cur_min_size = CoordW'(1 << (FracBits - 5));
  logic [CoordW-1:0] cur_size_gain = CoordW'(1 << (FracBits - 3));
  logic [DepthW-1:0] cur_min_depth = DepthW'(2);
  logic [DepthW-1:0] cur_max_depth = DepthW'(6);

  cell_s pending_cells[$];     // cells still to be offered on the input stream
  res_t  expected_cells[$];    // cells the block should emit, oldest first
  cell_s next_cell;
  int    mismatches = 0;
  int    cells_sent = 0;
  int    hold_left = 0;
  bit    held_once = 1'b0;
  bit    calm = 1'b0;          // no random idling on either side while set
  int    cycle_count = 0;

  quadtree_cell_refine_step_top DUT (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_wdata_i,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata,
    .m_axis_tuser,
    .m_axis_tlast
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // watchdog: a hung handshake or a lost result ends here
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= RunLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // clamp a signed child center into the 25 bit coordinate range
  function automatic logic [CoordW-1:0] clamp_coord(longint v);
    if (v < 0) return '0;
    if (v > longint'(TopCoord)) return TopCoord;
    return CoordW'(v);
  endfunction

  // exact test: smallest target size over center and corners below the cell size
  // corners live in doubled units so the half size stays an integer
  function automatic logic splits_on_size(logic [CoordW-1:0] cx, logic [CoordW-1:0] cy,
                                          logic [CoordW-1:0] sz);
    longint mid, lo_sum, hi_sum, m;
    logic [127:0] lhs, rhs;
    if (cur_min_size >= sz) return 1'b0;
    mid = 2 * longint'(cx) + 2 * longint'(cy);
    lo_sum = mid - 2 * longint'(sz);   // lower left corner, may go negative
    hi_sum = mid + 2 * longint'(sz);   // upper right corner
    // the other two corners share the center sum
    lo_sum = (lo_sum < 0) ? -lo_sum : lo_sum;
    m = mid;
    if (lo_sum < m) m = lo_sum;
    if (hi_sum < m) m = hi_sum;
    lhs = 128'(cur_size_gain) * 128'(m * m);
    rhs = 128'(sz - cur_min_size) << (2 * FracBits + 2);
    return lhs < rhs;
  endfunction

  // expected output cells for one input transfer
  task automatic refine_cell(input logic [TdataW-1:0] word);
    logic [CoordW-1:0] cx, cy, sz;
    logic [DepthW-1:0] dp;
    logic split;
    longint quarter;
    res_t kid;
    int k;
    int dx[4] = '{-1, 1, 1, -1};
    int dy[4] = '{-1, -1, 1, 1};
    cx = word[CoordW-1:0];
    cy = word[2*CoordW-1:CoordW];
    sz = word[3*CoordW-1:2*CoordW];
    dp = word[3*CoordW+DepthW-1:3*CoordW];
    if (dp < cur_min_depth) split = 1'b1;
    else if (dp < cur_max_depth) split = splits_on_size(cx, cy, sz);
    else split = 1'b0;
    if (!split) begin
      kid = '{x: cx, y: cy, size: sz, depth: dp, leaf: 1'b1, last: 1'b1};
      expected_cells.push_back(kid);
    end else begin
      quarter = longint'(sz >> 2);
      // children: lower left, lower right, upper right, upper left
      for (k = 0; k < 4; k++) begin
        kid.x = clamp_coord(longint'(cx) + dx[k] * quarter);
        kid.y = clamp_coord(longint'(cy) + dy[k] * quarter);
        kid.size = sz >> 1;
        kid.depth = dp + 1'b1;
        kid.leaf = 1'b0;
        kid.last = (k == 3);
        expected_cells.push_back(kid);
      end
    end
  endtask

  // random cell: raw codes, in-range values, aligned tree cells, cells near the origin
  function automatic cell_s random_cell();
    cell_s c;
    int unsigned lvl;
    case ($urandom_range(3))
      0: begin
        c.x = CoordW'($urandom);
        c.y = CoordW'($urandom);
        c.size = CoordW'($urandom);
        c.depth = DepthW'($urandom);
      end
      1: begin
        c.x = CoordW'($urandom_range(0, Unit));
        c.y = CoordW'($urandom_range(0, Unit));
        c.size = CoordW'(Unit >> $urandom_range(0, 12));
        c.depth = DepthW'($urandom_range(0, 15));
      end
      2: begin
        // a cell that a real refinement of the unit square would produce
        lvl = $urandom_range(0, 8);
        c.size = CoordW'(Unit >> lvl);
        c.x = CoordW'((2 * $urandom_range(0, (1 << lvl) - 1) + 1) << (FracBits - lvl - 1));
        c.y = CoordW'((2 * $urandom_range(0, (1 << lvl) - 1) + 1) << (FracBits - lvl - 1));
        c.depth = DepthW'(lvl);
      end
      default: begin
        c.x = CoordW'($urandom_range(0, 1 << 20));
        c.y = CoordW'($urandom_range(0, 1 << 20));
        c.size = CoordW'($urandom_range(0, 1 << 22));
        c.depth = DepthW'($urandom_range(0, 7));
      end
    endcase
    return c;
  endfunction

  task automatic offer(input int unsigned x, input int unsigned y, input int unsigned s,
                       input int unsigned d);
    cell_s c;
    c = '{x: CoordW'(x), y: CoordW'(y), size: CoordW'(s), depth: DepthW'(d)};
    pending_cells.push_back(c);
  endtask

  // write all four registers, one per cycle, write enable held across them
  task automatic load_settings(input logic [CoordW-1:0] ms, input logic [CoordW-1:0] sg,
                               input logic [DepthW-1:0] mind, input logic [DepthW-1:0] maxd);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= CfgMinSize;
    cfg_wdata_i <= CfgW'(ms);
    @(posedge clk_i);
    cfg_idx_i <= CfgSizeGain;
    cfg_wdata_i <= CfgW'(sg);
    @(posedge clk_i);
    cfg_idx_i <= CfgMinDepth;
    cfg_wdata_i <= CfgW'(mind);
    @(posedge clk_i);
    cfg_idx_i <= CfgMaxDepth;
    cfg_wdata_i <= CfgW'(maxd);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    cur_min_size = ms;
    cur_size_gain = sg;
    cur_min_depth = mind;
    cur_max_depth = maxd;
  endtask

  // wait until every cell went in and every expected cell came out, then settle
  task automatic drain();
    do @(negedge clk_i);
    while (pending_cells.size() != 0 || s_axis_tvalid || expected_cells.size() != 0);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic run_random(input int n);
    @(negedge clk_i);
    repeat (n) pending_cells.push_back(random_cell());
    drain();
  endtask

  // input side: keep tvalid and tdata until the transfer, random gaps between cells
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (pending_cells.size() != 0 && (calm || $urandom_range(99) >= 26)) begin
        next_cell = pending_cells.pop_front();
        s_axis_tdata <= TdataW'({next_cell.depth, next_cell.size, next_cell.y, next_cell.x});
        s_axis_tvalid <= 1'b1;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // long hold-off of the receiver while the sender keeps offering, so the queue
  // fills and s_axis_tready has to drop
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_left <= 0;
      held_once <= 1'b0;
    end else if (!held_once && cells_sent >= HoldAt) begin
      hold_left <= HoldCycles;
      held_once <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // prediction on each input transfer, checking on each output transfer, and the
  // receiver's tready with random stalls
  always @(posedge clk_i or negedge rst_ni) begin
    res_t got;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        refine_cell(s_axis_tdata);
        cells_sent = cells_sent + 1;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got = '{x: m_axis_tdata[CoordW-1:0], y: m_axis_tdata[2*CoordW-1:CoordW],
                size: m_axis_tdata[3*CoordW-1:2*CoordW],
                depth: m_axis_tdata[3*CoordW+DepthW-1:3*CoordW],
                leaf: m_axis_tuser, last: m_axis_tlast};
        if (expected_cells.size() == 0) begin
          if (mismatches < 10)
            $display("unexpected cell x=%h y=%h size=%h depth=%0d leaf=%b last=%b",
                     got.x, got.y, got.size, got.depth, got.leaf, got.last);
          mismatches = mismatches + 1;
        end else begin
          if (got.x !== expected_cells[0].x || got.y !== expected_cells[0].y ||
              got.size !== expected_cells[0].size || got.depth !== expected_cells[0].depth ||
              got.leaf !== expected_cells[0].leaf || got.last !== expected_cells[0].last) begin
            if (mismatches < 10) begin
              $display("cell mismatch expected x=%h y=%h size=%h depth=%0d leaf=%b last=%b",
                       expected_cells[0].x, expected_cells[0].y, expected_cells[0].size,
                       expected_cells[0].depth, expected_cells[0].leaf, expected_cells[0].last);
              $display("              actual   x=%h y=%h size=%h depth=%0d leaf=%b last=%b",
                       got.x, got.y, got.size, got.depth, got.leaf, got.last);
            end
            mismatches = mismatches + 1;
          end
          void'(expected_cells.pop_front());
        end
      end
      if (hold_left > 0) begin
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= calm || ($urandom_range(99) >= 26);
      end
    end
  end

  initial begin
    logic [CoordW-1:0] ms, sg;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed cells under the reset settings: 1/32 floor, 1/8 gain, depths 2 and 6
    @(negedge clk_i);
    offer(Unit / 2, Unit / 2, Unit, 0);             // root, shallower than min depth
    offer(0, 0, 0, 0);                              // all zero, zero sized children
    offer(TopCoord, TopCoord, TopCoord, 0);         // children clamp at the top
    offer(0, Unit, Unit, 1);                        // children clamp at zero
    offer(Unit / 2, Unit / 2, Unit / 4, 15);        // deepest level, kept
    offer(Unit / 2, Unit / 2, Unit / 4, 6);         // at max depth, kept
    offer(1 << 20, 1 << 20, 1 << 10, 3);            // floor above cell size
    offer(1 << 20, 1 << 20, Unit, 3);               // lower left corner goes negative
    offer(Unit, Unit, 1 << 20, 2);                  // far from origin, target too big
    // target at the lower left corner equals 2^20 exactly: equal keeps, one more splits
    offer((1 << 22) + (1 << 19), (1 << 22) + (1 << 19), 1 << 20, 3);
    offer((1 << 22) + (1 << 19), (1 << 22) + (1 << 19), (1 << 20) + 1, 3);
    offer((1 << 22) + (1 << 19), (1 << 22) + (1 << 19), (1 << 20) - 1, 3);
    offer(Unit, 0, Unit / 2, 4);
    offer(TopCoord, 0, TopCoord, 5);
    offer(0, TopCoord, 3, 1);                       // quarter offset truncates to zero
    offer(1 << 15, 1 << 15, 1 << 21, 5);            // splits into the max depth level
    drain();

    run_random(40);

    // floor zero, full gain, widest depth window; no idling, includes the hold-off
    load_settings('0, CoordW'(Unit), '0, DepthW'(15));
    calm = 1'b1;
    run_random(40);
    calm = 1'b0;

    // floor at 1.0, no gain, always split below level 15
    load_settings(CoordW'(Unit), '0, DepthW'(15), DepthW'(15));
    run_random(20);

    // nothing ever splits
    load_settings(TopCoord, TopCoord, '0, '0);
    run_random(15);

    repeat (3) begin
      ms = ($urandom_range(1)) ? CoordW'($urandom_range(0, 1 << 21)) : CoordW'($urandom);
      sg = ($urandom_range(1)) ? CoordW'($urandom_range(0, Unit)) : CoordW'($urandom);
      load_settings(ms, sg, DepthW'($urandom_range(0, 15)), DepthW'($urandom_range(0, 15)));
      run_random(20);
    end

    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
